[hdl/dcpb_pkg.sv]
// dcpb_pkg: shared types and constants for the drive command packet builder.
// Used by dcpb_front, dcpb_cmd_fifo, dcpb_back and drive_command_packet_builder.
// Depends on nothing.
`default_nettype none

package dcpb_pkg;

	// Value widths after saturation
	localparam int SPEED_W = 12;   // holds +-1200
	localparam int STEER_W = 11;   // holds +-900

	localparam logic signed [15:0] SPEED_MAX_IN = 16'sd1200;
	localparam logic signed [15:0] STEER_MAX_IN = 16'sd900;
	localparam logic signed [11:0] STEER_MAX_SUM = 12'sd900;
	localparam logic signed [12:0] SPEED_MAX_WIDE = 13'sd1200;

	// Configuration port
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 12;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_SERVO_OFFSET     = 3'd0,
		CFG_ASSIST_ENABLE    = 3'd1,
		CFG_ASSIST_THRESHOLD = 3'd2,
		CFG_ASSIST_GAIN      = 3'd3,
		CFG_ASSIST_LIMIT     = 3'd4,
		CFG_ASSIST_INVERT    = 3'd5
	} cfg_reg_t;

	// Frame bytes
	localparam logic [7:0] SYNC_HI   = 8'hAA;
	localparam logic [7:0] SYNC_LO   = 8'h55;
	localparam logic [7:0] LEN_SPEED = 8'h0B;
	localparam logic [7:0] CMD_SPEED = 8'h50;
	localparam logic [7:0] CMD_DIFF  = 8'h51;
	localparam logic [7:0] LEN_SERVO = 8'h11;
	localparam logic [7:0] CMD_SERVO = 8'h60;

	// Command queue depth
	localparam int QUEUE_DEPTH = 4;

	// One classified command, handed from front to back
	typedef struct packed {
		logic                      diff;     // differential frame
		logic signed [SPEED_W-1:0] speed_a;  // speed, or left speed
		logic signed [SPEED_W-1:0] speed_b;  // right speed
		logic signed [STEER_W-1:0] steer;
	} cmd_t;

endpackage

`default_nettype wire

[hdl/drive_command_packet_builder.sv]
// drive_command_packet_builder: top level; front pipeline, command queue and
// frame serializer. Depends on dcpb_pkg, dcpb_front, dcpb_cmd_fifo, dcpb_back.
//
//  channel | handshake            | payload
//  --------+----------------------+-----------------------------------------------
//  in      | in_valid / in_stall  | run_enable, stop_request, target_speed_mm_s,
//          |                      | steer_tenth_deg
//  out     | out_valid / out_stall| packet_byte, frame_end, last (28 per item)
//  cfg     | cfg_valid / cfg_ready| cfg_index, cfg_data (cfg_ready is always high)
//
// Each item yields 28 bytes at one byte per cycle while out_stall stays low;
// the serializer sets the sustained item rate. An accepted item passes the four
// front stages, the command queue and the serializer's command and output
// registers before its first byte appears. The front pipeline accepts a new item
// each cycle until the queue (QUEUE_DEPTH entries) is full and stage 4 holds an item.
// Reset (arst_n low) clears all configuration registers to 0 and empties the queue.
`default_nettype none

module drive_command_packet_builder #(
	parameter int QUEUE_DEPTH = dcpb_pkg::QUEUE_DEPTH
) (
	input  wire                                  clk,
	input  wire                                  arst_n,
	// configuration
	input  wire                                  cfg_valid,
	output logic                                 cfg_ready,
	input  wire  [dcpb_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  wire  [dcpb_pkg::CFG_DATA_W-1:0]      cfg_data,
	// input items
	input  wire                                  in_valid,
	output logic                                 in_stall,
	input  wire                                  run_enable,
	input  wire                                  stop_request,
	input  wire  signed [15:0]                   target_speed_mm_s,
	input  wire  signed [15:0]                   steer_tenth_deg,
	// result bytes
	output logic                                 out_valid,
	input  wire                                  out_stall,
	output logic [7:0]                           packet_byte,
	output logic                                 frame_end,
	output logic                                 last
);

	logic           push, pop, full, empty;
	dcpb_pkg::cmd_t push_cmd, head;

	// configuration writes are always taken
	assign cfg_ready = 1'b1;

	dcpb_front u_front (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg_we            (cfg_valid && cfg_ready),
		.cfg_index         (cfg_index),
		.cfg_data          (cfg_data),
		.in_valid          (in_valid),
		.in_stall          (in_stall),
		.run_enable        (run_enable),
		.stop_request      (stop_request),
		.target_speed_mm_s (target_speed_mm_s),
		.steer_tenth_deg   (steer_tenth_deg),
		.push              (push),
		.push_cmd          (push_cmd),
		.queue_full        (full)
	);

	dcpb_cmd_fifo #(
		.Depth (QUEUE_DEPTH)
	) u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.head     (head),
		.full     (full),
		.empty    (empty)
	);

	dcpb_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head        (head),
		.empty       (empty),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.packet_byte (packet_byte),
		.frame_end   (frame_end),
		.last        (last)
	);

endmodule

`default_nettype wire

[hdl/dcpb_front.sv]
// dcpb_front: configuration registers and the four-stage command pipeline
// (gating, saturation, assist computation). Depends on dcpb_pkg.
`default_nettype none

module dcpb_front (
	input  wire                                  clk,
	input  wire                                  arst_n,
	// configuration writes
	input  wire                                  cfg_we,
	input  wire  [dcpb_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  wire  [dcpb_pkg::CFG_DATA_W-1:0]      cfg_data,
	// input items
	input  wire                                  in_valid,
	output logic                                 in_stall,
	input  wire                                  run_enable,
	input  wire                                  stop_request,
	input  wire  signed [15:0]                   target_speed_mm_s,
	input  wire  signed [15:0]                   steer_tenth_deg,
	// toward the command queue
	output logic                                 push,
	output dcpb_pkg::cmd_t                       push_cmd,
	input  wire                                  queue_full
);

	localparam int SW = dcpb_pkg::SPEED_W;
	localparam int TW = dcpb_pkg::STEER_W;
	// floor(x/5) = (x * RECIP_5) >> 16 for x up to 2400
	localparam logic [14:0] RECIP_5 = 15'd13108;

	// configuration registers
	logic signed [10:0] servo_offset_q;
	logic               assist_enable_q;
	logic [9:0]         assist_threshold_q;
	logic [11:0]        assist_gain_q;
	logic [10:0]        assist_limit_q;
	logic               assist_invert_q;

	// pipeline control
	logic v_s1, v_s2, v_s3, v_s4;
	logic adv;

	// stage 1
	logic signed [SW-1:0] speed_s1;
	logic signed [TW-1:0] steer_s1;
	// stage 2
	logic signed [SW-1:0] speed_s2;
	logic signed [TW-1:0] steer_s2;
	logic [21:0]          prod_s2;
	logic [8:0]           quot_s2;
	logic                 en_s2;
	logic                 pos_s2;
	// stage 3
	logic signed [SW-1:0] speed_s3;
	logic signed [TW-1:0] steer_s3;
	logic [8:0]           assist_s3;
	logic                 diff_s3;
	logic                 neg_s3;
	// stage 4
	dcpb_pkg::cmd_t       cmd_s4;

	// write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			servo_offset_q     <= '0;
			assist_enable_q    <= 1'b0;
			assist_threshold_q <= '0;
			assist_gain_q      <= '0;
			assist_limit_q     <= '0;
			assist_invert_q    <= 1'b0;
		end else if (cfg_we) begin
			unique case (dcpb_pkg::cfg_reg_t'(cfg_index))
				dcpb_pkg::CFG_SERVO_OFFSET:     servo_offset_q     <= $signed(cfg_data[10:0]);
				dcpb_pkg::CFG_ASSIST_ENABLE:    assist_enable_q    <= cfg_data[0];
				dcpb_pkg::CFG_ASSIST_THRESHOLD: assist_threshold_q <= cfg_data[9:0];
				dcpb_pkg::CFG_ASSIST_GAIN:      assist_gain_q      <= cfg_data[11:0];
				dcpb_pkg::CFG_ASSIST_LIMIT:     assist_limit_q     <= cfg_data[10:0];
				dcpb_pkg::CFG_ASSIST_INVERT:    assist_invert_q    <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// advance the whole pipeline unless the last stage is blocked by a full queue
	assign adv      = !v_s4 || !queue_full;
	assign in_stall = !adv;
	assign push     = v_s4 && adv;
	assign push_cmd = cmd_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	// stage 1: gate by run/stop, saturate speed and steer, add servo offset
	logic signed [15:0] spd_gate, ang_gate;
	logic signed [SW-1:0] spd_sat;
	logic signed [TW-1:0] ang_sat;
	logic signed [11:0]   steer_sum;
	logic signed [TW-1:0] steer_sat;

	always_comb begin
		spd_gate = (run_enable && !stop_request) ? target_speed_mm_s : 16'sd0;
		ang_gate = run_enable ? steer_tenth_deg : 16'sd0;

		if (spd_gate > dcpb_pkg::SPEED_MAX_IN)
			spd_sat = dcpb_pkg::SPEED_MAX_IN[SW-1:0];
		else if (spd_gate < -dcpb_pkg::SPEED_MAX_IN)
			spd_sat = SW'(-dcpb_pkg::SPEED_MAX_IN);
		else
			spd_sat = spd_gate[SW-1:0];

		if (ang_gate > dcpb_pkg::STEER_MAX_IN)
			ang_sat = dcpb_pkg::STEER_MAX_IN[TW-1:0];
		else if (ang_gate < -dcpb_pkg::STEER_MAX_IN)
			ang_sat = TW'(-dcpb_pkg::STEER_MAX_IN);
		else
			ang_sat = ang_gate[TW-1:0];

		steer_sum = {ang_sat[TW-1], ang_sat} + {servo_offset_q[10], servo_offset_q};
		if (steer_sum > dcpb_pkg::STEER_MAX_SUM)
			steer_sat = dcpb_pkg::STEER_MAX_SUM[TW-1:0];
		else if (steer_sum < -dcpb_pkg::STEER_MAX_SUM)
			steer_sat = TW'(-dcpb_pkg::STEER_MAX_SUM);
		else
			steer_sat = steer_sum[TW-1:0];
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			speed_s1 <= spd_sat;
			steer_s1 <= steer_sat;
		end
	end

	// stage 2: magnitudes, gain product and the speed bound (2/5 of |speed|)
	logic signed [TW-1:0] steer_neg;
	logic signed [SW-1:0] speed_neg;
	logic [9:0]  abs_steer;
	logic [10:0] abs_speed;
	logic [9:0]  over;
	logic        over_thr;
	logic [21:0] prod;
	logic [26:0] quot_full;

	always_comb begin
		steer_neg = -steer_s1;
		speed_neg = -speed_s1;
		abs_steer = steer_s1[TW-1] ? steer_neg[9:0] : steer_s1[9:0];
		abs_speed = speed_s1[SW-1] ? speed_neg[10:0] : speed_s1[10:0];
		over_thr  = abs_steer > assist_threshold_q;
		over      = abs_steer - assist_threshold_q;
		prod      = 22'(over) * 22'(assist_gain_q);
		quot_full = 27'({abs_speed, 1'b0}) * 27'(RECIP_5);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			speed_s2 <= speed_s1;
			steer_s2 <= steer_s1;
			prod_s2  <= prod;
			quot_s2  <= quot_full[24:16];
			en_s2    <= assist_enable_q && over_thr && (speed_s1 != '0);
			pos_s2   <= steer_s1 > 0;
		end
	end

	// stage 3: assist = min(limit, gain term, speed bound)
	logic [13:0] gain_term;
	logic [8:0]  assist_min;

	always_comb begin
		gain_term  = prod_s2[21:8];
		assist_min = quot_s2;
		if (gain_term < 14'(assist_min))
			assist_min = gain_term[8:0];
		if (assist_limit_q < 11'(assist_min))
			assist_min = assist_limit_q[8:0];
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			speed_s3  <= speed_s2;
			steer_s3  <= steer_s2;
			assist_s3 <= assist_min;
			diff_s3   <= en_s2 && (assist_min != '0);
			neg_s3    <= !(pos_s2 ^ assist_invert_q);
		end
	end

	// stage 4: apply signed assist to left and right wheels, build the command
	logic signed [12:0] assist_sgn;
	logic signed [12:0] left_raw, right_raw;
	logic signed [SW-1:0] left_sat, right_sat;

	always_comb begin
		assist_sgn = neg_s3 ? -$signed({4'b0, assist_s3}) : $signed({4'b0, assist_s3});
		left_raw   = {speed_s3[SW-1], speed_s3} - assist_sgn;
		right_raw  = {speed_s3[SW-1], speed_s3} + assist_sgn;

		if (left_raw > dcpb_pkg::SPEED_MAX_WIDE)
			left_sat = dcpb_pkg::SPEED_MAX_WIDE[SW-1:0];
		else if (left_raw < -dcpb_pkg::SPEED_MAX_WIDE)
			left_sat = SW'(-dcpb_pkg::SPEED_MAX_WIDE);
		else
			left_sat = left_raw[SW-1:0];

		if (right_raw > dcpb_pkg::SPEED_MAX_WIDE)
			right_sat = dcpb_pkg::SPEED_MAX_WIDE[SW-1:0];
		else if (right_raw < -dcpb_pkg::SPEED_MAX_WIDE)
			right_sat = SW'(-dcpb_pkg::SPEED_MAX_WIDE);
		else
			right_sat = right_raw[SW-1:0];
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			cmd_s4.diff    <= diff_s3;
			cmd_s4.speed_a <= diff_s3 ? left_sat : speed_s3;
			cmd_s4.speed_b <= right_sat;
			cmd_s4.steer   <= steer_s3;
		end
	end

endmodule

`default_nettype wire

[hdl/dcpb_cmd_fifo.sv]
// dcpb_cmd_fifo: short command queue between the front pipeline and the
// frame serializer. Depends on dcpb_pkg.
`default_nettype none

module dcpb_cmd_fifo #(
	parameter int Depth = dcpb_pkg::QUEUE_DEPTH
) (
	input  wire             clk,
	input  wire             arst_n,
	input  wire             push,
	input  dcpb_pkg::cmd_t  push_cmd,
	input  wire             pop,
	output dcpb_pkg::cmd_t  head,
	output logic            full,
	output logic            empty
);

	localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int CntW = $clog2(Depth + 1);
	localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
	localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

	dcpb_pkg::cmd_t  entry_q [Depth];
	logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CntW-1:0] count_q;

	assign full  = (count_q == FullCnt);
	assign empty = (count_q == '0);
	assign head  = entry_q[rd_ptr_q];

	// store pushed commands
	always_ff @(posedge clk) begin
		if (push)
			entry_q[wr_ptr_q] <= push_cmd;
	end

	// advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !push)
		else $error("command pushed into a full queue");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		empty |-> !pop)
		else $error("command popped from an empty queue");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FullCnt)
		else $error("queue occupancy beyond depth");

endmodule

`default_nettype wire

[hdl/dcpb_back.sv]
// dcpb_back: frame serializer. Takes one command from the queue and sends its
// 28 frame bytes with running checksums through an output register.
// Depends on dcpb_pkg.
`default_nettype none

module dcpb_back (
	input  wire             clk,
	input  wire             arst_n,
	// from the command queue
	input  dcpb_pkg::cmd_t  head,
	input  wire             empty,
	output logic            pop,
	// result channel
	output logic            out_valid,
	input  wire             out_stall,
	output logic [7:0]      packet_byte,
	output logic            frame_end,
	output logic            last
);

	localparam logic [4:0] POS_SPEED_CS = 5'd10;
	localparam logic [4:0] POS_SERVO_CS = 5'd27;

	dcpb_pkg::cmd_t cur_q;
	logic           busy_q;
	logic [4:0]     cnt_q;
	logic [7:0]     cs_q;
	logic           out_valid_q;
	logic [7:0]     byte_q;
	logic           frame_end_q;
	logic           last_q;

	logic       load;
	logic       at_end;
	logic [7:0] next_byte;
	logic       next_fend;
	logic [7:0] a_hi, b_hi, st_hi;

	// output register may take a new byte when empty or being transferred
	assign load   = !out_valid_q || !out_stall;
	assign at_end = busy_q && (cnt_q == POS_SERVO_CS);
	assign pop    = !empty && (!busy_q || (load && at_end));

	assign out_valid   = out_valid_q;
	assign packet_byte = byte_q;
	assign frame_end   = frame_end_q;
	assign last        = last_q;

	// select the byte for the current position
	always_comb begin
		a_hi      = {{4{cur_q.speed_a[11]}}, cur_q.speed_a[11:8]};
		b_hi      = {{4{cur_q.speed_b[11]}}, cur_q.speed_b[11:8]};
		st_hi     = {{5{cur_q.steer[10]}}, cur_q.steer[10:8]};
		next_fend = (cnt_q == POS_SPEED_CS) || (cnt_q == POS_SERVO_CS);
		unique case (cnt_q)
			5'd0:  next_byte = dcpb_pkg::SYNC_HI;
			5'd1:  next_byte = dcpb_pkg::SYNC_LO;
			5'd2:  next_byte = dcpb_pkg::LEN_SPEED;
			5'd3:  next_byte = cur_q.diff ? dcpb_pkg::CMD_DIFF : dcpb_pkg::CMD_SPEED;
			5'd4:  next_byte = a_hi;
			5'd5:  next_byte = cur_q.speed_a[7:0];
			5'd6:  next_byte = cur_q.diff ? b_hi : 8'h00;
			5'd7:  next_byte = cur_q.diff ? cur_q.speed_b[7:0] : 8'h00;
			5'd10: next_byte = cs_q;
			5'd11: next_byte = dcpb_pkg::SYNC_HI;
			5'd12: next_byte = dcpb_pkg::SYNC_LO;
			5'd13: next_byte = dcpb_pkg::LEN_SERVO;
			5'd14: next_byte = dcpb_pkg::CMD_SERVO;
			5'd15: next_byte = st_hi;
			5'd16: next_byte = cur_q.steer[7:0];
			5'd27: next_byte = cs_q;
			default: next_byte = 8'h00;
		endcase
	end

	// hold the current command, step through its bytes, refill from the queue
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			cnt_q       <= '0;
			cs_q        <= '0;
			out_valid_q <= 1'b0;
			frame_end_q <= 1'b0;
			last_q      <= 1'b0;
		end else begin
			if (load) begin
				out_valid_q <= busy_q;
				if (busy_q) begin
					frame_end_q <= next_fend;
					last_q      <= at_end;
					cs_q        <= next_fend ? 8'h00 : cs_q + next_byte;
				end
			end
			// take a new command, or advance the byte position
			if (pop) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (load && busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (at_end)
					busy_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (pop)
			cur_q <= head;
		if (load && busy_q)
			byte_q <= next_byte;
	end

	a_last_ends_frame: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && last_q) |-> frame_end_q)
		else $error("last byte is not a checksum byte");

	a_pop_only_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> (!busy_q || at_end))
		else $error("command taken while a frame is still being sent");

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (cnt_q <= POS_SERVO_CS))
		else $error("byte position past end of item");

endmodule

`default_nettype wire

[tb/tb_top.sv]
// tb_top: self-checking testbench for drive_command_packet_builder.
// Predicts the 28 frame bytes of each command and checks every transfer in order.
// Depends on dcpb_pkg and drive_command_packet_builder.

module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int DRIVE_FRAME_LEN = 11;
	localparam int SERVO_FRAME_LEN = 17;
	localparam int BYTES_PER_CMD   = DRIVE_FRAME_LEN + SERVO_FRAME_LEN;
	localparam int SPEED_LIMIT     = 1200;
	localparam int STEER_LIMIT     = 900;
	localparam int DRAIN_CYCLES    = 12;
	localparam int MAX_REPORTS     = 10;
	localparam int TIMEOUT_NS      = 2_000_000;
	localparam int CFG_SEGMENT     = 40;

	// register indexes past the last defined register
	localparam logic [dcpb_pkg::CFG_IDX_W-1:0] CFG_SPARE_A = 3'd6;
	localparam logic [dcpb_pkg::CFG_IDX_W-1:0] CFG_SPARE_B = 3'd7;

	typedef struct packed {
		logic [7:0] pbyte;
		logic       fend;
		logic       lst;
	} frame_byte_t;

	logic                            clk;
	logic                            arst_n;
	logic                            cfg_valid;
	logic                            cfg_ready;
	logic [dcpb_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [dcpb_pkg::CFG_DATA_W-1:0] cfg_data;
	logic                            in_valid;
	logic                            in_stall;
	logic                            run_enable;
	logic                            stop_request;
	logic signed [15:0]              target_speed_mm_s;
	logic signed [15:0]              steer_tenth_deg;
	logic                            out_valid;
	logic                            out_stall;
	logic [7:0]                      packet_byte;
	logic                            frame_end;
	logic                            last;

	// register copies, at reset values
	logic signed [10:0] servo_ofs  = '0;
	logic               assist_on  = 1'b0;
	logic [9:0]         assist_thr = '0;
	logic [11:0]        assist_gn  = '0;
	logic [10:0]        assist_lim = '0;
	logic               assist_inv = 1'b0;

	frame_byte_t expected_bytes[$];

	int send_pct     = 0;
	int stall_pct    = 0;
	int hold_req_len = 0;
	int hold_req_id  = 0;

	int commands_sent = 0;
	int bytes_checked = 0;
	int diff_frames   = 0;
	int reg_writes    = 0;
	int error_count   = 0;

	drive_command_packet_builder dut (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg_valid         (cfg_valid),
		.cfg_ready         (cfg_ready),
		.cfg_index         (cfg_index),
		.cfg_data          (cfg_data),
		.in_valid          (in_valid),
		.in_stall          (in_stall),
		.run_enable        (run_enable),
		.stop_request      (stop_request),
		.target_speed_mm_s (target_speed_mm_s),
		.steer_tenth_deg   (steer_tenth_deg),
		.out_valid         (out_valid),
		.out_stall         (out_stall),
		.packet_byte       (packet_byte),
		.frame_end         (frame_end),
		.last              (last)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#TIMEOUT_NS;
		$display("timeout with %0d bytes still expected", expected_bytes.size());
		$display("drive_command_packet_builder verification failed");
		$finish;
	end

	function automatic int clamp(int v, int lim);
		if (v > lim) return lim;
		if (v < -lim) return -lim;
		return v;
	endfunction

	// Compute the speed (or differential) frame and the servo frame of one command
	function automatic void build_command_frames(logic run, logic stop,
			logic signed [15:0] spd_in, logic signed [15:0] str_in);
		int speed, angle, steer, left, right;
		int abs_steer, abs_speed, over, assist, by_speed, side_assist, i;
		logic use_diff;
		logic [7:0] fb [BYTES_PER_CMD];
		logic [7:0] sum;
		speed = 0;
		angle = 0;
		use_diff = 1'b0;
		if (run) begin
			angle = int'(str_in);
			if (!stop)
				speed = int'(spd_in);
		end
		speed = clamp(speed, SPEED_LIMIT);
		steer = clamp(clamp(angle, STEER_LIMIT) + int'(servo_ofs), STEER_LIMIT);
		left = speed;
		right = speed;
		abs_steer = (steer < 0) ? -steer : steer;
		abs_speed = (speed < 0) ? -speed : speed;

		// split the speed when the assist is active and nonzero
		if (assist_on && abs_steer > int'(assist_thr) && speed != 0) begin
			over = abs_steer - int'(assist_thr);
			assist = (over * int'(assist_gn)) >> 8;
			by_speed = (abs_speed * 2) / 5;
			if (by_speed < assist) assist = by_speed;
			if (int'(assist_lim) < assist) assist = int'(assist_lim);
			if (assist > 0) begin
				side_assist = (steer > 0) ? assist : -assist;
				if (assist_inv) side_assist = -side_assist;
				left = clamp(speed - side_assist, SPEED_LIMIT);
				right = clamp(speed + side_assist, SPEED_LIMIT);
				use_diff = 1'b1;
			end
		end

		for (i = 0; i < BYTES_PER_CMD; i++)
			fb[i] = 8'h00;
		fb[0] = dcpb_pkg::SYNC_HI;
		fb[1] = dcpb_pkg::SYNC_LO;
		fb[2] = dcpb_pkg::LEN_SPEED;
		if (use_diff) begin
			fb[3] = dcpb_pkg::CMD_DIFF;
			fb[4] = left[15:8];
			fb[5] = left[7:0];
			fb[6] = right[15:8];
			fb[7] = right[7:0];
			diff_frames++;
		end else begin
			fb[3] = dcpb_pkg::CMD_SPEED;
			fb[4] = speed[15:8];
			fb[5] = speed[7:0];
		end
		fb[DRIVE_FRAME_LEN + 0] = dcpb_pkg::SYNC_HI;
		fb[DRIVE_FRAME_LEN + 1] = dcpb_pkg::SYNC_LO;
		fb[DRIVE_FRAME_LEN + 2] = dcpb_pkg::LEN_SERVO;
		fb[DRIVE_FRAME_LEN + 3] = dcpb_pkg::CMD_SERVO;
		fb[DRIVE_FRAME_LEN + 4] = steer[15:8];
		fb[DRIVE_FRAME_LEN + 5] = steer[7:0];

		// queue bytes, closing each frame with its running sum
		sum = 8'h00;
		for (i = 0; i < BYTES_PER_CMD; i++) begin
			if (i == DRIVE_FRAME_LEN - 1 || i == BYTES_PER_CMD - 1) begin
				expected_bytes.push_back('{sum, 1'b1, i == BYTES_PER_CMD - 1});
				sum = 8'h00;
			end else begin
				expected_bytes.push_back('{fb[i], 1'b0, 1'b0});
				sum = sum + fb[i];
			end
		end
	endfunction

	task automatic flag_error(string msg);
		error_count++;
		if (error_count <= MAX_REPORTS)
			$display("ERROR @%0t: %s", $realtime, msg);
	endtask

	// Check every output transfer against the oldest expected byte
	always @(posedge clk) begin : check_bytes
		frame_byte_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_bytes.size() == 0) begin
				flag_error($sformatf("unexpected byte %02h end %b last %b",
					packet_byte, frame_end, last));
			end else begin
				want = expected_bytes.pop_front();
				bytes_checked++;
				if (packet_byte !== want.pbyte || frame_end !== want.fend
						|| last !== want.lst)
					flag_error($sformatf(
						"byte exp %02h/%b/%b got %02h/%b/%b (byte/end/last)",
						want.pbyte, want.fend, want.lst, packet_byte, frame_end, last));
			end
		end
	end

	// Drive the receiver stall: random, or held for a requested stretch
	initial begin : drive_out_stall
		int hold_left;
		int seen_id;
		hold_left = 0;
		seen_id = 0;
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req_id != seen_id) begin
				seen_id = hold_req_id;
				hold_left = hold_req_len;
			end
			if (hold_left > 0) begin
				out_stall <= 1'b1;
				hold_left--;
			end else begin
				out_stall <= ($urandom_range(99) < stall_pct);
			end
		end
	end

	// Offer one command; return at the falling edge after its transfer
	task automatic send_cmd(logic run, logic stop,
			logic signed [15:0] spd, logic signed [15:0] str);
		while ($urandom_range(99) < send_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid = 1'b1;
		run_enable = run;
		stop_request = stop;
		target_speed_mm_s = spd;
		steer_tenth_deg = str;
		do @(posedge clk); while (in_stall);
		build_command_frames(run, stop, spd, str);
		commands_sent++;
		@(negedge clk);
	endtask

	// Drop valid and wait until every expected byte has come out
	task automatic wait_drained();
		in_valid = 1'b0;
		while (expected_bytes.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(logic [dcpb_pkg::CFG_IDX_W-1:0] idx,
			logic [dcpb_pkg::CFG_DATA_W-1:0] value);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = value;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			dcpb_pkg::CFG_SERVO_OFFSET:     servo_ofs = value[10:0];
			dcpb_pkg::CFG_ASSIST_ENABLE:    assist_on = value[0];
			dcpb_pkg::CFG_ASSIST_THRESHOLD: assist_thr = value[9:0];
			dcpb_pkg::CFG_ASSIST_GAIN:      assist_gn = value[11:0];
			dcpb_pkg::CFG_ASSIST_LIMIT:     assist_lim = value[10:0];
			dcpb_pkg::CFG_ASSIST_INVERT:    assist_inv = value[0];
			default: ;
		endcase
		reg_writes++;
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// Equal shares of full-range, moderate (up to 1.25 x span), near-saturation and tiny values
	function automatic logic [15:0] pick_value(int span);
		int v;
		int wide;
		wide = span + span / 4;
		case ($urandom_range(3))
			0: v = $urandom;
			1: v = $urandom_range(0, 2 * wide) - wide;
			2: begin
				v = span + $urandom_range(1);
				if ($urandom_range(1)) v = -v;
			end
			default: v = $urandom_range(0, 40) - 20;
		endcase
		return v[15:0];
	endfunction

	task automatic send_random_cmd();
		send_cmd($urandom_range(99) < 85, $urandom_range(99) < 15,
			pick_value(SPEED_LIMIT), pick_value(STEER_LIMIT));
	endtask

	// Load every register with random data, unused upper bits included
	task automatic randomize_config();
		logic [dcpb_pkg::CFG_DATA_W-1:0] ofs, thr, gn, lim;
		ofs = ($urandom_range(99) < 20) ? 12'($urandom) : 12'($urandom_range(0, 400) - 200);
		thr = 12'($urandom_range(0, 700));
		if ($urandom_range(99) < 10) thr[9:0] = 10'h3FF;
		thr[11:10] = 2'($urandom);
		gn = ($urandom_range(99) < 30) ? 12'($urandom_range(0, 600)) : 12'($urandom);
		lim = ($urandom_range(99) < 10) ? 12'($urandom) : 12'($urandom_range(0, 1200));
		write_reg(dcpb_pkg::CFG_SERVO_OFFSET, ofs);
		write_reg(dcpb_pkg::CFG_ASSIST_ENABLE, {11'($urandom), 1'($urandom_range(99) < 75)});
		write_reg(dcpb_pkg::CFG_ASSIST_THRESHOLD, thr);
		write_reg(dcpb_pkg::CFG_ASSIST_GAIN, gn);
		write_reg(dcpb_pkg::CFG_ASSIST_LIMIT, lim);
		write_reg(dcpb_pkg::CFG_ASSIST_INVERT, 12'($urandom));
	endtask

	// Field extremes, run and stop gating at reset settings
	task automatic test_gating_and_saturation();
		send_cmd(1'b1, 1'b0, 16'sd0, 16'sd0);
		send_cmd(1'b1, 1'b0, 16'sd32767, 16'sd32767);
		send_cmd(1'b1, 1'b0, 16'sh8000, 16'sh8000);
		send_cmd(1'b1, 1'b0, 16'sd1200, 16'sd900);
		send_cmd(1'b1, 1'b0, -16'sd1201, -16'sd901);
		send_cmd(1'b0, 1'b0, 16'sd500, 16'sd300);
		send_cmd(1'b1, 1'b1, 16'sd800, -16'sd450);
		send_cmd(1'b0, 1'b1, -16'sd1, -16'sd1);
		wait_drained();
	endtask

	// Servo offset at and past its range, also while not running
	task automatic test_servo_offset();
		write_reg(dcpb_pkg::CFG_SERVO_OFFSET, 12'h3FF);
		send_cmd(1'b0, 1'b0, 16'sd100, -16'sd200);
		send_cmd(1'b1, 1'b0, 16'sd100, 16'sd900);
		wait_drained();
		write_reg(dcpb_pkg::CFG_SERVO_OFFSET, 12'hC00);
		send_cmd(1'b1, 1'b0, -16'sd300, 16'sh8000);
		send_cmd(1'b0, 1'b1, 16'sd0, 16'sd0);
		wait_drained();
		write_reg(dcpb_pkg::CFG_SERVO_OFFSET, 12'(-900));
		send_cmd(1'b1, 1'b0, 16'sd700, 16'sd450);
		wait_drained();
		write_reg(dcpb_pkg::CFG_SERVO_OFFSET, 12'h000);
	endtask

	// Differential assist: each bound, both sides, invert, threshold out of reach
	task automatic test_assist();
		write_reg(dcpb_pkg::CFG_ASSIST_ENABLE, 12'h001);
		write_reg(dcpb_pkg::CFG_ASSIST_THRESHOLD, 12'd100);
		write_reg(dcpb_pkg::CFG_ASSIST_GAIN, 12'd256);
		write_reg(dcpb_pkg::CFG_ASSIST_LIMIT, 12'd300);
		write_reg(dcpb_pkg::CFG_ASSIST_INVERT, 12'h000);
		send_cmd(1'b1, 1'b0, 16'sd1000, 16'sd400);
		send_cmd(1'b1, 1'b0, -16'sd1000, -16'sd400);
		send_cmd(1'b1, 1'b0, 16'sd500, 16'sd50);
		send_cmd(1'b1, 1'b0, 16'sd0, 16'sd600);
		send_cmd(1'b1, 1'b0, 16'sd5, 16'sd600);
		send_cmd(1'b1, 1'b0, 16'sd2, -16'sd600);
		wait_drained();
		write_reg(dcpb_pkg::CFG_ASSIST_INVERT, 12'h001);
		send_cmd(1'b1, 1'b0, 16'sd1000, 16'sd400);
		wait_drained();
		write_reg(dcpb_pkg::CFG_ASSIST_GAIN, 12'hFFF);
		write_reg(dcpb_pkg::CFG_ASSIST_LIMIT, 12'd1200);
		send_cmd(1'b1, 1'b0, -16'sd1200, 16'sd900);
		wait_drained();
		write_reg(dcpb_pkg::CFG_ASSIST_THRESHOLD, 12'h3FF);
		write_reg(CFG_SPARE_A, 12'hFFF);
		write_reg(CFG_SPARE_B, 12'h000);
		send_cmd(1'b1, 1'b0, 16'sd1000, 16'sd900);
		wait_drained();
		write_reg(dcpb_pkg::CFG_ASSIST_THRESHOLD, 12'd0);
		write_reg(dcpb_pkg::CFG_ASSIST_ENABLE, 12'hFFE);
		send_cmd(1'b1, 1'b0, 16'sd1000, 16'sd900);
		wait_drained();
	endtask

	task automatic test_random_traffic(int send_idle, int recv_stall, int count);
		int i;
		send_pct = send_idle;
		stall_pct <= recv_stall;
		for (i = 0; i < count; i++) begin
			if (i % CFG_SEGMENT == 0) begin
				wait_drained();
				randomize_config();
			end
			send_random_cmd();
		end
		wait_drained();
	endtask

	// Hold the receiver off while commands keep coming, so the input stalls
	task automatic test_receiver_holdoff();
		int i;
		send_pct = 0;
		stall_pct <= 0;
		randomize_config();
		hold_req_len <= 300;
		hold_req_id <= hold_req_id + 1;
		for (i = 0; i < 16; i++)
			send_random_cmd();
		wait_drained();
		for (i = 0; i < 6; i++)
			send_random_cmd();
		wait_drained();
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		run_enable = 1'b0;
		stop_request = 1'b0;
		target_speed_mm_s = '0;
		steer_tenth_deg = '0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_gating_and_saturation();
		test_servo_offset();
		test_assist();
		test_random_traffic(21, 85, 142);
		test_random_traffic(85, 21, 142);
		test_random_traffic(0, 0, 142);
		test_receiver_holdoff();

		if (expected_bytes.size() != 0)
			flag_error($sformatf("%0d expected bytes never arrived", expected_bytes.size()));
		$display("Run covered %0d commands (%0d differential frames), %0d bytes checked,",
			commands_sent, diff_frames, bytes_checked);
		$display("%0d register writes and %0d errors.", reg_writes, error_count);
		if (error_count == 0)
			$display("drive_command_packet_builder verification clean");
		else
			$display("drive_command_packet_builder verification failed");
		$finish;
	end

endmodule

[filelist.f]
hdl/dcpb_pkg.sv
hdl/dcpb_front.sv
hdl/dcpb_cmd_fifo.sv
hdl/dcpb_back.sv
hdl/drive_command_packet_builder.sv
tb/tb_top.sv
